// ===== sv/tcce_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tcce_pkg: shared constants for the text console character engine
// Screen geometry, control character codes and field widths.
// ----------------------------------------------------------------------------
package tcce_pkg;

   // screen geometry
   localparam int COLUMNS    = 80;
   localparam int ROWS       = 25;
   localparam int TAB_WIDTH  = 4;
   localparam int CELL_COUNT = ROWS * COLUMNS;

   // field and counter widths
   localparam int ROW_W     = 5;
   localparam int COL_W     = 7;
   localparam int CHAR_W    = 8;
   localparam int CELL_W    = 16;
   localparam int ADDR_W    = $clog2(CELL_COUNT);
   localparam int TAB_CNT_W = $clog2(TAB_WIDTH + 1);

   // control character codes
   localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'd8;
   localparam logic [CHAR_W-1:0] CH_TAB       = 8'd9;
   localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'd10;
   localparam logic [CHAR_W-1:0] CH_RETURN    = 8'd13;
   localparam logic [CHAR_W-1:0] CH_SPACE     = 8'd32;

   // colour after reset: light grey on black
   localparam logic [CHAR_W-1:0] RESET_COLOR = 8'd7;

   // request kinds
   localparam logic KIND_PRINT = 1'b0;
   localparam logic KIND_READ  = 1'b1;

endpackage
`default_nettype wire

// ===== sv/tcce_ram.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tcce_ram: generic simple dual-port RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module tcce_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 2000
) (
   input  wire                      clock,
   input  wire                      wr_en,
   input  wire [$clog2(DEPTH)-1:0]  wr_addr,
   input  wire [WIDTH-1:0]          wr_data,
   input  wire                      rd_en,
   input  wire [$clog2(DEPTH)-1:0]  rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule
`default_nettype wire

// ===== sv/text_console_char_engine_core.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// text_console_char_engine_core: character-cell text console engine
// Keeps a ROWS x COLUMNS screen of 16-bit cells and a cursor; prints
// character bytes and reads back cells.
// ----------------------------------------------------------------------------
// Usage
//   req_*  : one beat per command. req_kind 0 prints req_char_code at the
//            cursor (newline, return, backspace, tab handled), 1 reads the
//            visible cell at req_read_row / req_read_col.
//   rsp_*  : one beat per command: cursor after the step, the read cell
//            (0 for prints) and whether the screen scrolled.
//   csr_*  : write enable and data for the colour attribute; write it only
//            while no command is in flight.
// Sequence (req_ready is high only while the sequencer is idle)
//   Return or out-of-range read: DECODE, FINISH. Newline: DECODE, NEWLINE,
//   FINISH. Print or backspace: DECODE, ADDR, WRITE, FINISH. Read: DECODE,
//   ADDR, RD_REQ, RD_DATA, FINISH. Tab: ADDR, WRITE per blank. Row end adds
//   NEWLINE; a scroll adds ADDR, then SCROLL clears the bottom row one cell
//   per cycle through the screen RAM's write port.
// Reset
//   After reset the RAM is filled with blanks, one cell per cycle, and
//   req_ready stays low until all CELL_COUNT (2000) cells are written.
// Stall
//   The response sits in an output register; the next command is taken
//   while it waits, and holds in its final step until the register frees.
// ----------------------------------------------------------------------------
module text_console_char_engine_core (
   input  wire         clock,
   input  wire         reset,
   // request channel
   input  wire         req_valid,
   output logic        req_ready,
   input  wire         req_kind,
   input  wire  [7:0]  req_char_code,
   input  wire  [4:0]  req_read_row,
   input  wire  [6:0]  req_read_col,
   // response channel
   output logic        rsp_valid,
   input  wire         rsp_ready,
   output logic [4:0]  rsp_cursor_row_out,
   output logic [6:0]  rsp_cursor_col_out,
   output logic [15:0] rsp_cell_value,
   output logic        rsp_scrolled,
   // configuration
   input  wire         csr_wr_en,
   input  wire  [7:0]  csr_wr_data
);

   localparam int ROW_W  = tcce_pkg::ROW_W;
   localparam int COL_W  = tcce_pkg::COL_W;
   localparam int CHAR_W = tcce_pkg::CHAR_W;
   localparam int CELL_W = tcce_pkg::CELL_W;
   localparam int ADDR_W = tcce_pkg::ADDR_W;
   localparam int TCW    = tcce_pkg::TAB_CNT_W;

   // sequencer states
   localparam logic [3:0] S_CLEAR   = 4'd0;
   localparam logic [3:0] S_IDLE    = 4'd1;
   localparam logic [3:0] S_DECODE  = 4'd2;
   localparam logic [3:0] S_ADDR    = 4'd3;
   localparam logic [3:0] S_WRITE   = 4'd4;
   localparam logic [3:0] S_NEWLINE = 4'd5;
   localparam logic [3:0] S_SCROLL  = 4'd6;
   localparam logic [3:0] S_RD_REQ  = 4'd7;
   localparam logic [3:0] S_RD_DATA = 4'd8;
   localparam logic [3:0] S_FINISH  = 4'd9;

   // print actions
   localparam logic [2:0] ACT_CHAR  = 3'd0;
   localparam logic [2:0] ACT_TAB   = 3'd1;
   localparam logic [2:0] ACT_BACK  = 3'd2;
   localparam logic [2:0] ACT_READ  = 3'd3;
   localparam logic [2:0] ACT_OTHER = 3'd4;

   // registers
   logic [3:0]        state_ff,    state_in;
   logic [ROW_W-1:0]  cur_row_ff,  cur_row_in;
   logic [COL_W-1:0]  cur_col_ff,  cur_col_in;
   logic [ROW_W-1:0]  top_ff,      top_in;
   logic [CHAR_W-1:0] color_ff,    color_in;
   logic [ADDR_W-1:0] addr_ff,     addr_in;
   logic [COL_W-1:0]  clr_cnt_ff,  clr_cnt_in;
   logic [TCW-1:0]    tab_cnt_ff,  tab_cnt_in;
   logic              clearing_ff, clearing_in;
   logic              scroll_ff,   scroll_in;
   logic [CELL_W-1:0] cell_ff,     cell_in;
   logic [2:0]        act_ff,      act_in;
   logic [CHAR_W-1:0] ch_ff,       ch_in;
   logic [ROW_W-1:0]  rrow_ff,     rrow_in;
   logic [COL_W-1:0]  rcol_ff,     rcol_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [ROW_W-1:0]  rsp_row_ff,  rsp_row_in;
   logic [COL_W-1:0]  rsp_col_ff,  rsp_col_in;
   logic [CELL_W-1:0] rsp_cell_ff, rsp_cell_in;
   logic              rsp_scr_ff,  rsp_scr_in;

   // RAM ports
   logic              ram_wr_en;
   logic [CELL_W-1:0] ram_wr_data;
   logic              ram_rd_en;
   logic [CELL_W-1:0] ram_rd_data;

   // shared address unit: ring row then row * COLUMNS + column
   logic [ROW_W-1:0]  au_row;
   logic [COL_W-1:0]  au_col;
   logic [ROW_W:0]    au_sum;
   logic [ROW_W-1:0]  au_prow;
   logic [ADDR_W-1:0] au_addr;

   always_comb begin
      if (act_ff == ACT_READ) begin
         au_row = rrow_ff;
         au_col = rcol_ff;
      end else begin
         au_row = cur_row_ff;
         au_col = cur_col_ff;
      end
      au_sum = {1'b0, top_ff} + {1'b0, au_row};
      if (au_sum >= (ROW_W+1)'(tcce_pkg::ROWS)) begin
         au_prow = ROW_W'(au_sum - (ROW_W+1)'(tcce_pkg::ROWS));
      end else begin
         au_prow = au_sum[ROW_W-1:0];
      end
      au_addr = ADDR_W'(au_prow) * ADDR_W'(tcce_pkg::COLUMNS) + ADDR_W'(au_col);
   end

   // cursor step helpers
   logic [COL_W:0] col_plus;
   logic [TCW-1:0] tab_plus;
   logic           row_end;
   logic           last_row;

   assign col_plus = {1'b0, cur_col_ff} + (COL_W+1)'(1);
   assign tab_plus = tab_cnt_ff + TCW'(1);
   assign row_end  = (col_plus == (COL_W+1)'(tcce_pkg::COLUMNS));
   assign last_row = (cur_row_ff == ROW_W'(tcce_pkg::ROWS - 1));

   assign req_ready = (state_ff == S_IDLE);

   // sequencer and datapath next state
   always_comb begin
      state_in     = state_ff;
      cur_row_in   = cur_row_ff;
      cur_col_in   = cur_col_ff;
      top_in       = top_ff;
      color_in     = csr_wr_en ? csr_wr_data : color_ff;
      addr_in      = addr_ff;
      clr_cnt_in   = clr_cnt_ff;
      tab_cnt_in   = tab_cnt_ff;
      clearing_in  = clearing_ff;
      scroll_in    = scroll_ff;
      cell_in      = cell_ff;
      act_in       = act_ff;
      ch_in        = ch_ff;
      rrow_in      = rrow_ff;
      rcol_in      = rcol_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_row_in   = rsp_row_ff;
      rsp_col_in   = rsp_col_ff;
      rsp_cell_in  = rsp_cell_ff;
      rsp_scr_in   = rsp_scr_ff;
      ram_wr_en    = 1'b0;
      ram_wr_data  = '0;
      ram_rd_en    = 1'b0;

      case (state_ff)
         // blank fill of the whole screen after reset
         S_CLEAR: begin
            ram_wr_en   = 1'b1;
            ram_wr_data = {tcce_pkg::RESET_COLOR, tcce_pkg::CH_SPACE};
            addr_in     = addr_ff + ADDR_W'(1);
            if (addr_ff == ADDR_W'(tcce_pkg::CELL_COUNT - 1)) begin
               state_in = S_IDLE;
            end
         end

         S_IDLE: begin
            if (req_valid) begin
               ch_in   = req_char_code;
               rrow_in = req_read_row;
               rcol_in = req_read_col;
               act_in  = (req_kind == tcce_pkg::KIND_READ) ? ACT_READ : ACT_OTHER;
               state_in = S_DECODE;
            end
         end

         // classify the command and do the cursor-only work
         S_DECODE: begin
            scroll_in   = 1'b0;
            cell_in     = '0;
            tab_cnt_in  = '0;
            clearing_in = 1'b0;
            if (act_ff == ACT_READ) begin
               if ({1'b0, rrow_ff} >= (ROW_W+1)'(tcce_pkg::ROWS) ||
                   {1'b0, rcol_ff} >= (COL_W+1)'(tcce_pkg::COLUMNS)) begin
                  state_in = S_FINISH;
               end else begin
                  state_in = S_ADDR;
               end
            end else begin
               case (ch_ff)
                  tcce_pkg::CH_NEWLINE: begin
                     state_in = S_NEWLINE;
                  end
                  tcce_pkg::CH_RETURN: begin
                     cur_col_in = '0;
                     state_in   = S_FINISH;
                  end
                  tcce_pkg::CH_BACKSPACE: begin
                     act_in = ACT_BACK;
                     if (cur_col_ff == '0) begin
                        // at the origin the cursor stays put
                        if (cur_row_ff != '0) begin
                           cur_row_in = cur_row_ff - ROW_W'(1);
                           cur_col_in = COL_W'(tcce_pkg::COLUMNS - 1);
                        end
                     end else begin
                        cur_col_in = cur_col_ff - COL_W'(1);
                     end
                     state_in = S_ADDR;
                  end
                  tcce_pkg::CH_TAB: begin
                     act_in   = ACT_TAB;
                     state_in = S_ADDR;
                  end
                  default: begin
                     act_in   = ACT_CHAR;
                     state_in = S_ADDR;
                  end
               endcase
            end
         end

         // register the cell address
         S_ADDR: begin
            addr_in = au_addr;
            if (clearing_ff) begin
               clr_cnt_in = '0;
               state_in   = S_SCROLL;
            end else if (act_ff == ACT_READ) begin
               state_in = S_RD_REQ;
            end else begin
               state_in = S_WRITE;
            end
         end

         // write one cell; advance the cursor for characters and tabs
         S_WRITE: begin
            ram_wr_en = 1'b1;
            if (act_ff == ACT_CHAR) begin
               ram_wr_data = {color_ff, ch_ff};
            end else begin
               ram_wr_data = {color_ff, tcce_pkg::CH_SPACE};
            end
            case (act_ff)
               ACT_CHAR: begin
                  cur_col_in = col_plus[COL_W-1:0];
                  state_in   = row_end ? S_NEWLINE : S_FINISH;
               end
               ACT_TAB: begin
                  cur_col_in = col_plus[COL_W-1:0];
                  tab_cnt_in = tab_plus;
                  if (row_end) begin
                     state_in = S_NEWLINE;
                  end else if (tab_plus < TCW'(tcce_pkg::TAB_WIDTH)) begin
                     state_in = S_ADDR;
                  end else begin
                     state_in = S_FINISH;
                  end
               end
               default: begin
                  state_in = S_FINISH;
               end
            endcase
         end

         // next row, scrolling the ring past the last row
         S_NEWLINE: begin
            cur_col_in = '0;
            if (last_row) begin
               top_in = (top_ff == ROW_W'(tcce_pkg::ROWS - 1)) ? '0 : top_ff + ROW_W'(1);
               scroll_in   = 1'b1;
               clearing_in = 1'b1;
               act_in      = ACT_OTHER;
               state_in    = S_ADDR;
            end else begin
               cur_row_in = cur_row_ff + ROW_W'(1);
               state_in   = S_FINISH;
            end
         end

         // zero the new bottom row one cell per cycle
         S_SCROLL: begin
            ram_wr_en   = 1'b1;
            ram_wr_data = '0;
            addr_in     = addr_ff + ADDR_W'(1);
            clr_cnt_in  = clr_cnt_ff + COL_W'(1);
            if (clr_cnt_ff == COL_W'(tcce_pkg::COLUMNS - 1)) begin
               clearing_in = 1'b0;
               state_in    = S_FINISH;
            end
         end

         S_RD_REQ: begin
            ram_rd_en = 1'b1;
            state_in  = S_RD_DATA;
         end

         S_RD_DATA: begin
            cell_in  = ram_rd_data;
            state_in = S_FINISH;
         end

         // hand the result to the output register once it is free
         S_FINISH: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_row_in   = cur_row_ff;
               rsp_col_in   = cur_col_ff;
               rsp_cell_in  = cell_ff;
               rsp_scr_in   = scroll_ff;
               state_in     = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         cur_row_ff   <= '0;
         cur_col_ff   <= '0;
         top_ff       <= '0;
         color_ff     <= tcce_pkg::RESET_COLOR;
         addr_ff      <= '0;
         clearing_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cur_row_ff   <= cur_row_in;
         cur_col_ff   <= cur_col_in;
         top_ff       <= top_in;
         color_ff     <= color_in;
         addr_ff      <= addr_in;
         clearing_ff  <= clearing_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      clr_cnt_ff  <= clr_cnt_in;
      tab_cnt_ff  <= tab_cnt_in;
      scroll_ff   <= scroll_in;
      cell_ff     <= cell_in;
      act_ff      <= act_in;
      ch_ff       <= ch_in;
      rrow_ff     <= rrow_in;
      rcol_ff     <= rcol_in;
      rsp_row_ff  <= rsp_row_in;
      rsp_col_ff  <= rsp_col_in;
      rsp_cell_ff <= rsp_cell_in;
      rsp_scr_ff  <= rsp_scr_in;
   end

   // screen store
   tcce_ram #(
      .WIDTH (CELL_W),
      .DEPTH (tcce_pkg::CELL_COUNT)
   ) u_screen (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (addr_ff),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (addr_ff),
      .rd_data (ram_rd_data)
   );

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_cursor_row_out = rsp_row_ff;
   assign rsp_cursor_col_out = rsp_col_ff;
   assign rsp_cell_value     = rsp_cell_ff;
   assign rsp_scrolled       = rsp_scr_ff;

endmodule
`default_nettype wire

// ===== verif/tb.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tb: self-checking bench for text_console_char_engine_core
// Drives print and read commands over the req_ channel and mirrors the
// screen, cursor and scroll ring in a behavioural model. Every rsp_ beat is
// checked field by field against the model. Colour is changed between phases
// while the engine is idle; both channels stall at random but in the last phase.
// ----------------------------------------------------------------------------
module tb;

   localparam int WATCHDOG_LIMIT = 20000;
   localparam int DRAIN_CYCLES   = 200;

   localparam int ROWS       = tcce_pkg::ROWS;
   localparam int COLUMNS    = tcce_pkg::COLUMNS;
   localparam int TAB_WIDTH  = tcce_pkg::TAB_WIDTH;
   localparam int CELL_COUNT = tcce_pkg::CELL_COUNT;
   localparam int ROW_W      = tcce_pkg::ROW_W;
   localparam int COL_W      = tcce_pkg::COL_W;
   localparam int CHAR_W     = tcce_pkg::CHAR_W;
   localparam int CELL_W     = tcce_pkg::CELL_W;

   typedef struct packed {
      logic              kind;
      logic [CHAR_W-1:0] code;
      logic [ROW_W-1:0]  rrow;
      logic [COL_W-1:0]  rcol;
   } console_cmd_type;

   typedef struct packed {
      logic [ROW_W-1:0]  row;
      logic [COL_W-1:0]  col;
      logic [CELL_W-1:0] cell_word;
      logic              scrolled;
   } console_report_type;

   logic              clock         = 1'b0;
   logic              reset         = 1'b1;
   logic              req_valid     = 1'b0;
   logic              req_kind      = 1'b0;
   logic [7:0]        req_char_code = '0;
   logic [4:0]        req_read_row  = '0;
   logic [6:0]        req_read_col  = '0;
   logic              rsp_ready     = 1'b0;
   logic              csr_wr_en     = 1'b0;
   logic [7:0]        csr_wr_data   = '0;
   wire               req_ready;
   wire               rsp_valid;
   wire  [4:0]        rsp_cursor_row_out;
   wire  [6:0]        rsp_cursor_col_out;
   wire  [15:0]       rsp_cell_value;
   wire               rsp_scrolled;

   // mirror of the console state
   logic [CELL_W-1:0] screen_mirror [CELL_COUNT];
   int                cur_row;
   int                cur_col;
   int                top_row;
   logic [7:0]        text_colour;

   console_cmd_type    cmd_backlog [$];
   console_report_type console_reports [$];
   console_cmd_type    active_cmd;
   bit                allow_idle = 1'b1;
   int                error_count = 0;
   int                send_gap = 0;
   int                stall_left = 0;
   int                quiet_cycles = 0;

   text_console_char_engine_core DUT (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_kind           (req_kind),
      .req_char_code      (req_char_code),
      .req_read_row       (req_read_row),
      .req_read_col       (req_read_col),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_cursor_row_out (rsp_cursor_row_out),
      .rsp_cursor_col_out (rsp_cursor_col_out),
      .rsp_cell_value     (rsp_cell_value),
      .rsp_scrolled       (rsp_scrolled),
      .csr_wr_en          (csr_wr_en),
      .csr_wr_data        (csr_wr_data)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // physical cell of a visible row through the scroll ring
   function automatic int cell_addr(int vrow, int col);
      return ((top_row + vrow) % ROWS) * COLUMNS + col;
   endfunction

   // newline; returns 1 when the screen scrolled
   function automatic bit advance_line();
      int c;
      cur_col = 0;
      cur_row++;
      if (cur_row >= ROWS) begin
         top_row = (top_row + 1) % ROWS;
         cur_row = ROWS - 1;
         for (c = 0; c < COLUMNS; c++) screen_mirror[cell_addr(cur_row, c)] = '0;
         return 1'b1;
      end
      return 1'b0;
   endfunction

   // apply one command to the mirror and return the report it yields
   function automatic console_report_type run_console_cmd(console_cmd_type cmd);
      console_report_type rep;
      int n;
      rep = '0;
      if (cmd.kind == tcce_pkg::KIND_READ) begin
         if (cmd.rrow < ROWS && cmd.rcol < COLUMNS)
            rep.cell_word = screen_mirror[cell_addr(cmd.rrow, cmd.rcol)];
      end else begin
         case (cmd.code)
            tcce_pkg::CH_NEWLINE: begin
               rep.scrolled = advance_line();
            end
            tcce_pkg::CH_RETURN: begin
               cur_col = 0;
            end
            tcce_pkg::CH_BACKSPACE: begin
               // wraps to the end of the previous row, sticks at the origin
               if (cur_col == 0) begin
                  if (cur_row != 0) begin
                     cur_row--;
                     cur_col = COLUMNS - 1;
                  end
               end else begin
                  cur_col--;
               end
               screen_mirror[cell_addr(cur_row, cur_col)] =
                  {text_colour, tcce_pkg::CH_SPACE};
            end
            tcce_pkg::CH_TAB: begin
               // blanks up to the tab width, never past the row end
               n = 0;
               while (n < TAB_WIDTH && cur_col < COLUMNS) begin
                  screen_mirror[cell_addr(cur_row, cur_col)] =
                     {text_colour, tcce_pkg::CH_SPACE};
                  cur_col++;
                  n++;
               end
               if (cur_col >= COLUMNS) rep.scrolled = advance_line();
            end
            default: begin
               screen_mirror[cell_addr(cur_row, cur_col)] = {text_colour, cmd.code};
               cur_col++;
               if (cur_col >= COLUMNS) rep.scrolled = advance_line();
            end
         endcase
      end
      rep.row = ROW_W'(cur_row);
      rep.col = COL_W'(cur_col);
      return rep;
   endfunction

   function automatic void push_cmd(logic kind, logic [7:0] code, logic [4:0] r,
                                    logic [6:0] c);
      console_cmd_type cmd;
      cmd.kind = kind;
      cmd.code = code;
      cmd.rrow = r;
      cmd.rcol = c;
      cmd_backlog.push_back(cmd);
   endfunction

   // one command of the random mix; unused fields carry random bits
   function automatic console_cmd_type random_cmd(int newline_pct);
      console_cmd_type cmd;
      int pick;
      cmd.kind = tcce_pkg::KIND_PRINT;
      cmd.code = CHAR_W'($urandom);
      cmd.rrow = ROW_W'($urandom);
      cmd.rcol = COL_W'($urandom);
      pick = $urandom_range(0, 99);
      if (pick < 20) begin
         cmd.kind = tcce_pkg::KIND_READ;
         if ($urandom_range(0, 4) != 0) begin
            cmd.rrow = ROW_W'($urandom_range(0, ROWS - 1));
            cmd.rcol = COL_W'($urandom_range(0, COLUMNS - 1));
         end
      end else if (pick < 20 + newline_pct) begin
         cmd.code = tcce_pkg::CH_NEWLINE;
      end else if (pick < 27 + newline_pct) begin
         cmd.code = tcce_pkg::CH_TAB;
      end else if (pick < 34 + newline_pct) begin
         cmd.code = tcce_pkg::CH_BACKSPACE;
      end else if (pick < 37 + newline_pct) begin
         cmd.code = tcce_pkg::CH_RETURN;
      end
      return cmd;
   endfunction

   task automatic queue_random_cmds(int count, int newline_pct);
      console_cmd_type cmd;
      int made;
      int run;
      made = 0;
      while (made < count) begin
         if ($urandom_range(0, 39) == 0) begin
            // run of plain text, long enough to wrap a row now and then
            run = $urandom_range(10, 85);
            repeat (run) begin
               cmd = random_cmd(0);
               cmd.kind = tcce_pkg::KIND_PRINT;
               cmd.code = CHAR_W'($urandom_range(32, 126));
               cmd_backlog.push_back(cmd);
            end
            made += run;
         end else begin
            cmd_backlog.push_back(random_cmd(newline_pct));
            made++;
         end
      end
   endtask

   // hold off until every command is in and every report is back
   task automatic wait_drained();
      do @(negedge clock);
      while (cmd_backlog.size() != 0 || req_valid || console_reports.size() != 0);
   endtask

   task automatic write_colour(logic [7:0] value);
      @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      text_colour  = value;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   // request driver: predicts each beat as it is accepted
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         send_gap   = 0;
      end else if (!req_valid || req_ready) begin
         if (req_valid) console_reports.push_back(run_console_cmd(active_cmd));
         if (send_gap > 0) begin
            send_gap--;
            req_valid <= 1'b0;
         end else if (cmd_backlog.size() > 0) begin
            active_cmd     = cmd_backlog.pop_front();
            req_valid     <= 1'b1;
            req_kind      <= active_cmd.kind;
            req_char_code <= active_cmd.code;
            req_read_row  <= active_cmd.rrow;
            req_read_col  <= active_cmd.rcol;
            if (allow_idle && $urandom_range(0, 5) == 0) send_gap = $urandom_range(1, 11);
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // response monitor and back-pressure
   always @(posedge clock) begin
      console_report_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (console_reports.size() == 0) begin
               error_count++;
               if (error_count <= 10)
                  $display("ERROR: unexpected beat row=%0d col=%0d cell=%h scrolled=%b",
                           rsp_cursor_row_out, rsp_cursor_col_out, rsp_cell_value,
                           rsp_scrolled);
            end else begin
               want = console_reports.pop_front();
               if (rsp_cursor_row_out !== want.row || rsp_cursor_col_out !== want.col ||
                   rsp_cell_value !== want.cell_word || rsp_scrolled !== want.scrolled) begin
                  error_count++;
                  if (error_count <= 10)
                     $display({"ERROR: beat mismatch exp row=%0d col=%0d cell=%h scr=%b",
                               " got row=%0d col=%0d cell=%h scr=%b"},
                              want.row, want.col, want.cell_word, want.scrolled,
                              rsp_cursor_row_out, rsp_cursor_col_out, rsp_cell_value,
                              rsp_scrolled);
               end
            end
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_ready <= 1'b0;
         end else if (allow_idle && $urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(1, 11) - 1;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // watchdog on cycles with no beat on either channel
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
         end
      end
   end

   // stimulus sequence
   initial begin
      for (int i = 0; i < CELL_COUNT; i++)
         screen_mirror[i] = {tcce_pkg::RESET_COLOR, tcce_pkg::CH_SPACE};
      cur_row     = 0;
      cur_col     = 0;
      top_row     = 0;
      text_colour = tcce_pkg::RESET_COLOR;

      // directed: corners, control codes and out-of-range reads
      push_cmd(tcce_pkg::KIND_PRINT, tcce_pkg::CH_BACKSPACE, 5'd3, 7'd9); // at origin
      push_cmd(tcce_pkg::KIND_READ,  8'hA5, 5'd0, 7'd0);
      push_cmd(tcce_pkg::KIND_PRINT, 8'h00, 5'd31, 7'd127);
      push_cmd(tcce_pkg::KIND_PRINT, 8'hFF, 5'd0, 7'd0);
      push_cmd(tcce_pkg::KIND_PRINT, 8'h41, 5'd17, 7'd85);
      push_cmd(tcce_pkg::KIND_READ,  8'hFF, 5'd0, 7'd1);
      push_cmd(tcce_pkg::KIND_READ,  8'h00, 5'd0, 7'd2);
      push_cmd(tcce_pkg::KIND_PRINT, tcce_pkg::CH_RETURN, 5'd0, 7'd0);
      push_cmd(tcce_pkg::KIND_READ,  8'h5A, 5'd0, 7'd0);
      push_cmd(tcce_pkg::KIND_PRINT, tcce_pkg::CH_NEWLINE, 5'd0, 7'd0);
      push_cmd(tcce_pkg::KIND_PRINT, tcce_pkg::CH_BACKSPACE, 5'd0, 7'd0); // wraps back
      push_cmd(tcce_pkg::KIND_READ,  8'h00, 5'd0, 7'd79);
      push_cmd(tcce_pkg::KIND_PRINT, tcce_pkg::CH_TAB, 5'd0, 7'd0);  // clipped at row end
      push_cmd(tcce_pkg::KIND_PRINT, tcce_pkg::CH_TAB, 5'd0, 7'd0);
      push_cmd(tcce_pkg::KIND_READ,  8'h00, 5'd1, 7'd3);
      push_cmd(tcce_pkg::KIND_READ,  8'h00, 5'd25, 7'd0);
      push_cmd(tcce_pkg::KIND_READ,  8'h00, 5'd0, 7'd80);
      push_cmd(tcce_pkg::KIND_READ,  8'hFF, 5'd31, 7'd127);
      push_cmd(tcce_pkg::KIND_READ,  8'h00, 5'd24, 7'd79);
      push_cmd(tcce_pkg::KIND_PRINT, tcce_pkg::CH_NEWLINE, 5'd0, 7'd0);
      push_cmd(tcce_pkg::KIND_PRINT, 8'h7F, 5'd0, 7'd0);
      push_cmd(tcce_pkg::KIND_READ,  8'h00, 5'd2, 7'd0);

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // random phases at different colours; each starts from an idle engine
      wait_drained();
      write_colour(8'h00);
      queue_random_cmds(200, 10);

      wait_drained();
      write_colour(8'hFF);
      queue_random_cmds(200, 10);

      wait_drained();
      write_colour(8'($urandom));
      queue_random_cmds(200, 25);                        // scroll-heavy

      wait_drained();
      allow_idle = 1'b0;
      write_colour(tcce_pkg::RESET_COLOR);
      queue_random_cmds(250, 12);

      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
`default_nettype wire

// ===== text_console_char_engine_core.f =====
sv/tcce_pkg.sv
sv/tcce_ram.sv
sv/text_console_char_engine_core.sv
verif/tb.sv
